// ===== hdl/jov_pkg.sv =====
// ----------------------------------------------------------------------------
// jov_pkg
// Shared types, constants and small character functions for the JSON object
// validator.
// ----------------------------------------------------------------------------
`default_nettype none

package jov_pkg;

    // Deepest allowed nesting of objects and arrays.
    localparam int MAX_DEPTH = 64;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);

    // Result codes on the verdict field.
    localparam logic [1:0] VERDICT_PENDING  = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
    localparam logic [1:0] VERDICT_REJECTED = 2'd2;

    // Which keyword is being matched.
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // Grammar position. The string modes carry a separate key/value flag.
    typedef enum logic [4:0] {
        M_FIRST, M_BOM, M_PRE, M_OBJ_OPEN, M_OBJ_NEXT, M_COLON, M_VALUE,
        M_ARR_OPEN, M_AFTER, M_DONE, M_LIT,
        M_N_SIGN, M_N_ZERO, M_N_INT, M_N_DOT, M_N_FRAC, M_N_E, M_N_ESIGN, M_N_EXP,
        M_STR, M_ESC, M_HEX, M_SBS, M_SU, M_LHEX
    } t_mode;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Hex digit value; bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = c - 8'h57;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end else begin
            d = 8'h10;
        end
        hex_of = d[4:0];
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] which);
        case (which)
            LIT_FALSE: lit_len = 3'd5;
            default:   lit_len = 3'd4;
        endcase
    endfunction

    function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [2:0] idx);
        logic [39:0] s;
        case (which)
            LIT_TRUE:  s = {8'h00, "eurt"};
            LIT_FALSE: s = "eslaf";
            default:   s = {8'h00, "llun"};
        endcase
        lit_char = s[idx*8 +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/json_object_validator_unit.sv =====
// ----------------------------------------------------------------------------
// json_object_validator_unit
// Streaming well-formedness check of a JSON document whose top-level value is
// an object, one byte of text per word.
// ----------------------------------------------------------------------------
// Usage: the document enters on the input channel (i_valid / o_ready) one byte
// per word, with i_last_byte set on its final byte. Every input word yields
// exactly one result word on the output channel (o_valid / i_ready) holding
// the verdict (pending, accepted or rejected) and the nesting level after that
// byte. The block takes one byte per clock cycle while the output is not
// stalled. A result appears in the cycle after its byte is accepted, from the
// output register. All grammar state, the container stack and the UTF-8 and
// escape progress update in the cycle the byte is accepted, so the next byte
// can follow immediately. The container stack is a shift register: the
// innermost kind sits at bit 0. When the receiver stalls, the output register
// holds its word and o_ready stays high only if that word is being taken in
// the same cycle, so nothing is lost or repeated. A rejection freezes the
// state until the last byte. After reset (synchronous, active low) the block
// is at the start-of-document state with no result pending; after the last
// byte of a document its grammar state is back at the start.
// ----------------------------------------------------------------------------
`default_nettype none

module json_object_validator_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [7:0]                 i_text_byte,
    input  wire logic                       i_last_byte,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [1:0]                      o_verdict,
    output logic [jov_pkg::DEPTH_W-1:0]     o_nesting_level
);

    localparam int DW = jov_pkg::DEPTH_W;
    localparam int SD = jov_pkg::MAX_DEPTH;

    jov_pkg::t_mode r_mode, n_mode;
    logic           r_val, n_val;
    logic [SD-1:0]  r_stack, n_stack;
    logic [DW-1:0]  r_depth, n_depth;
    logic [1:0]     r_bom, n_bom;
    logic [1:0]     r_u8_rem, n_u8_rem;
    logic [1:0]     r_u8_len, n_u8_len;
    logic [20:0]    r_u8_val, n_u8_val;
    logic [15:0]    r_hex_val, n_hex_val;
    logic [2:0]     r_hex_cnt, n_hex_cnt;
    logic [2:0]     r_lit_idx, n_lit_idx;
    logic [1:0]     r_lit_which, n_lit_which;
    logic           r_failed, n_failed;

    logic           r_out_valid;
    logic [1:0]     r_out_verdict, n_out_verdict;
    logic [DW-1:0]  r_out_level;

    logic           in_acc;

    assign o_ready         = !r_out_valid || i_ready;
    assign in_acc          = i_valid && o_ready;
    assign o_valid         = r_out_valid;
    assign o_verdict       = r_out_verdict;
    assign o_nesting_level = r_out_level;

    // Next-state logic for one byte.
    always_comb begin
        logic [7:0]  c;
        logic        fail, consumed, is_num, is_e;
        logic        do_start, do_open, open_kind, do_close, close_kind;
        logic [4:0]  h;
        logic [15:0] hv;
        logic [20:0] uv, minv;
        logic [2:0]  hc;
        jov_pkg::t_mode eff;

        c          = i_text_byte;
        fail       = 1'b0;
        consumed   = 1'b0;
        do_start   = 1'b0;
        do_open    = 1'b0;
        open_kind  = 1'b0;
        do_close   = 1'b0;
        close_kind = 1'b0;
        is_e       = (c == 8'h65) || (c == 8'h45);
        h          = jov_pkg::hex_of(c);
        hv         = {r_hex_val[11:0], h[3:0]};
        hc         = r_hex_cnt + 3'd1;
        uv         = {r_u8_val[14:0], c[5:0]};
        minv       = 21'h0;
        eff        = r_mode;

        n_mode      = r_mode;
        n_val       = r_val;
        n_stack     = r_stack;
        n_depth     = r_depth;
        n_bom       = r_bom;
        n_u8_rem    = r_u8_rem;
        n_u8_len    = r_u8_len;
        n_u8_val    = r_u8_val;
        n_hex_val   = r_hex_val;
        n_hex_cnt   = r_hex_cnt;
        n_lit_idx   = r_lit_idx;
        n_lit_which = r_lit_which;

        // Number modes: a byte that cannot extend a complete number ends it and is
        // then judged as the byte after a value; an incomplete number rejects it.
        is_num = 1'b1;
        case (r_mode)
            jov_pkg::M_N_SIGN: begin
                consumed = 1'b1;
                if (c == 8'h30) n_mode = jov_pkg::M_N_ZERO;
                else if (jov_pkg::is_digit(c)) n_mode = jov_pkg::M_N_INT;
                else fail = 1'b1;
            end
            jov_pkg::M_N_ZERO, jov_pkg::M_N_INT: begin
                if (jov_pkg::is_digit(c)) begin
                    consumed = 1'b1;
                    if (r_mode == jov_pkg::M_N_ZERO) fail = 1'b1;
                end else if (c == 8'h2E) begin
                    consumed = 1'b1;
                    n_mode   = jov_pkg::M_N_DOT;
                end else if (is_e) begin
                    consumed = 1'b1;
                    n_mode   = jov_pkg::M_N_E;
                end
            end
            jov_pkg::M_N_DOT: begin
                consumed = 1'b1;
                if (jov_pkg::is_digit(c)) n_mode = jov_pkg::M_N_FRAC;
                else fail = 1'b1;
            end
            jov_pkg::M_N_FRAC: begin
                if (jov_pkg::is_digit(c)) begin
                    consumed = 1'b1;
                end else if (is_e) begin
                    consumed = 1'b1;
                    n_mode   = jov_pkg::M_N_E;
                end
            end
            jov_pkg::M_N_E: begin
                consumed = 1'b1;
                if (c == 8'h2B || c == 8'h2D) n_mode = jov_pkg::M_N_ESIGN;
                else if (jov_pkg::is_digit(c)) n_mode = jov_pkg::M_N_EXP;
                else fail = 1'b1;
            end
            jov_pkg::M_N_ESIGN: begin
                consumed = 1'b1;
                if (jov_pkg::is_digit(c)) n_mode = jov_pkg::M_N_EXP;
                else fail = 1'b1;
            end
            jov_pkg::M_N_EXP: begin
                if (jov_pkg::is_digit(c)) consumed = 1'b1;
            end
            default: begin
                is_num = 1'b0;
            end
        endcase

        if (is_num && !consumed) begin
            eff    = jov_pkg::M_AFTER;
            n_mode = jov_pkg::M_AFTER;
        end

        if (!consumed) begin
            case (eff)
                jov_pkg::M_FIRST: begin
                    if (c == 8'hEF) begin
                        n_bom  = 2'd1;
                        n_mode = jov_pkg::M_BOM;
                    end else if (c == 8'h7B) begin
                        do_open = 1'b1;
                    end else if (jov_pkg::is_ws(c)) begin
                        n_mode = jov_pkg::M_PRE;
                    end else begin
                        fail = 1'b1;
                    end
                end
                jov_pkg::M_BOM: begin
                    if (r_bom == 2'd1 && c == 8'hBB) begin
                        n_bom = 2'd2;
                    end else if (r_bom == 2'd2 && c == 8'hBF) begin
                        n_bom  = 2'd0;
                        n_mode = jov_pkg::M_PRE;
                    end else begin
                        fail = 1'b1;
                    end
                end
                jov_pkg::M_PRE: begin
                    if (c == 8'h7B) do_open = 1'b1;
                    else if (!jov_pkg::is_ws(c)) fail = 1'b1;
                end
                jov_pkg::M_OBJ_OPEN: begin
                    if (!jov_pkg::is_ws(c)) begin
                        if (c == 8'h7D) begin
                            do_close = 1'b1;
                        end else if (c == 8'h22) begin
                            n_mode = jov_pkg::M_STR;
                            n_val  = 1'b0;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                end
                jov_pkg::M_OBJ_NEXT: begin
                    if (!jov_pkg::is_ws(c)) begin
                        if (c == 8'h22) begin
                            n_mode = jov_pkg::M_STR;
                            n_val  = 1'b0;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                end
                jov_pkg::M_COLON: begin
                    if (!jov_pkg::is_ws(c)) begin
                        if (c == 8'h3A) n_mode = jov_pkg::M_VALUE;
                        else fail = 1'b1;
                    end
                end
                jov_pkg::M_VALUE: begin
                    if (!jov_pkg::is_ws(c)) do_start = 1'b1;
                end
                jov_pkg::M_ARR_OPEN: begin
                    if (!jov_pkg::is_ws(c)) begin
                        if (c == 8'h5D) begin
                            do_close   = 1'b1;
                            close_kind = 1'b1;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                end
                jov_pkg::M_AFTER: begin
                    if (!jov_pkg::is_ws(c)) begin
                        if (c == 8'h2C) begin
                            if (r_depth == '0) fail = 1'b1;
                            else if (r_stack[0]) n_mode = jov_pkg::M_VALUE;
                            else n_mode = jov_pkg::M_OBJ_NEXT;
                        end else if (c == 8'h7D) begin
                            do_close = 1'b1;
                        end else if (c == 8'h5D) begin
                            do_close   = 1'b1;
                            close_kind = 1'b1;
                        end else begin
                            fail = 1'b1;
                        end
                    end
                end
                jov_pkg::M_DONE: begin
                    if (!jov_pkg::is_ws(c)) fail = 1'b1;
                end
                jov_pkg::M_LIT: begin
                    if (r_lit_idx >= jov_pkg::lit_len(r_lit_which) ||
                        c != jov_pkg::lit_char(r_lit_which, r_lit_idx)) begin
                        fail = 1'b1;
                    end else begin
                        n_lit_idx = r_lit_idx + 3'd1;
                        if (n_lit_idx == jov_pkg::lit_len(r_lit_which)) begin
                            n_mode = jov_pkg::M_AFTER;
                        end
                    end
                end
                jov_pkg::M_STR: begin
                    if (r_u8_rem != 2'd0) begin
                        if (c[7:6] != 2'b10) begin
                            fail = 1'b1;
                        end else begin
                            n_u8_val = uv;
                            n_u8_rem = r_u8_rem - 2'd1;
                            if (n_u8_rem == 2'd0) begin
                                case (r_u8_len)
                                    2'd1:    minv = 21'h80;
                                    2'd2:    minv = 21'h800;
                                    default: minv = 21'h10000;
                                endcase
                                if (uv < minv || uv > 21'h10FFFF ||
                                    (uv >= 21'hD800 && uv <= 21'hDFFF)) fail = 1'b1;
                            end
                        end
                    end else if (c == 8'h22) begin
                        n_mode = r_val ? jov_pkg::M_AFTER : jov_pkg::M_COLON;
                    end else if (c < 8'h20) begin
                        fail = 1'b1;
                    end else if (c == 8'h5C) begin
                        n_mode = jov_pkg::M_ESC;
                    end else if (c[7]) begin
                        if (c[7:5] == 3'b110) begin
                            n_u8_len = 2'd1;
                            n_u8_rem = 2'd1;
                            n_u8_val = {16'h0, c[4:0]};
                        end else if (c[7:4] == 4'b1110) begin
                            n_u8_len = 2'd2;
                            n_u8_rem = 2'd2;
                            n_u8_val = {17'h0, c[3:0]};
                        end else if (c[7:3] == 5'b11110) begin
                            n_u8_len = 2'd3;
                            n_u8_rem = 2'd3;
                            n_u8_val = {18'h0, c[2:0]};
                        end else begin
                            fail = 1'b1;
                        end
                    end
                end
                jov_pkg::M_ESC: begin
                    if (c == 8'h22 || c == 8'h5C || c == 8'h2F || c == 8'h62 ||
                        c == 8'h66 || c == 8'h6E || c == 8'h72 || c == 8'h74) begin
                        n_mode = jov_pkg::M_STR;
                    end else if (c == 8'h75) begin
                        n_hex_cnt = 3'd0;
                        n_hex_val = 16'h0;
                        n_mode    = jov_pkg::M_HEX;
                    end else begin
                        fail = 1'b1;
                    end
                end
                jov_pkg::M_HEX, jov_pkg::M_LHEX: begin
                    if (h[4]) begin
                        fail = 1'b1;
                    end else begin
                        n_hex_val = hv;
                        n_hex_cnt = hc;
                        if (hc >= 3'd4) begin
                            if (eff == jov_pkg::M_HEX) begin
                                if (hv >= 16'hD800 && hv <= 16'hDBFF) n_mode = jov_pkg::M_SBS;
                                else if (hv >= 16'hDC00 && hv <= 16'hDFFF) fail = 1'b1;
                                else n_mode = jov_pkg::M_STR;
                            end else begin
                                if (hv >= 16'hDC00 && hv <= 16'hDFFF) n_mode = jov_pkg::M_STR;
                                else fail = 1'b1;
                            end
                        end
                    end
                end
                jov_pkg::M_SBS: begin
                    if (c == 8'h5C) n_mode = jov_pkg::M_SU;
                    else fail = 1'b1;
                end
                jov_pkg::M_SU: begin
                    if (c == 8'h75) begin
                        n_hex_cnt = 3'd0;
                        n_hex_val = 16'h0;
                        n_mode    = jov_pkg::M_LHEX;
                    end else begin
                        fail = 1'b1;
                    end
                end
                default: begin
                    fail = 1'b1;
                end
            endcase
        end

        // Start of a value inside an object member or an array.
        if (do_start) begin
            if (c == 8'h22) begin
                n_mode = jov_pkg::M_STR;
                n_val  = 1'b1;
            end else if (c == 8'h7B) begin
                do_open = 1'b1;
            end else if (c == 8'h5B) begin
                do_open   = 1'b1;
                open_kind = 1'b1;
            end else if (c == 8'h74 || c == 8'h66 || c == 8'h6E) begin
                n_lit_which = (c == 8'h74) ? jov_pkg::LIT_TRUE :
                              (c == 8'h66) ? jov_pkg::LIT_FALSE : jov_pkg::LIT_NULL;
                n_lit_idx   = 3'd1;
                n_mode      = jov_pkg::M_LIT;
            end else if (c == 8'h2D) begin
                n_mode = jov_pkg::M_N_SIGN;
            end else if (c == 8'h30) begin
                n_mode = jov_pkg::M_N_ZERO;
            end else if (jov_pkg::is_digit(c)) begin
                n_mode = jov_pkg::M_N_INT;
            end else begin
                fail = 1'b1;
            end
        end

        if (do_open) begin
            if (r_depth >= DW'(SD)) begin
                fail = 1'b1;
            end else begin
                n_stack = {r_stack[SD-2:0], open_kind};
                n_depth = r_depth + 1'b1;
                n_mode  = open_kind ? jov_pkg::M_ARR_OPEN : jov_pkg::M_OBJ_OPEN;
            end
        end

        if (do_close) begin
            if (r_depth == '0 || r_stack[0] != close_kind) begin
                fail = 1'b1;
            end else begin
                n_stack = {1'b0, r_stack[SD-1:1]};
                n_depth = r_depth - 1'b1;
                n_mode  = (n_depth == '0) ? jov_pkg::M_DONE : jov_pkg::M_AFTER;
            end
        end

        // A rejected document ignores further bytes.
        if (r_failed) begin
            n_depth = r_depth;
            n_mode  = r_mode;
        end
        n_failed = r_failed || fail;

        if (i_last_byte) begin
            n_out_verdict = (!n_failed && n_mode == jov_pkg::M_DONE) ?
                            jov_pkg::VERDICT_ACCEPTED : jov_pkg::VERDICT_REJECTED;
        end else begin
            n_out_verdict = n_failed ? jov_pkg::VERDICT_REJECTED : jov_pkg::VERDICT_PENDING;
        end
    end

    // Grammar state. The last byte of a document returns it to the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_acc && i_last_byte)) begin
            r_mode      <= jov_pkg::M_FIRST;
            r_val       <= 1'b0;
            r_stack     <= '0;
            r_depth     <= '0;
            r_bom       <= 2'd0;
            r_u8_rem    <= 2'd0;
            r_u8_len    <= 2'd0;
            r_u8_val    <= 21'h0;
            r_hex_val   <= 16'h0;
            r_hex_cnt   <= 3'd0;
            r_lit_idx   <= 3'd0;
            r_lit_which <= 2'd0;
            r_failed    <= 1'b0;
        end else if (in_acc && !r_failed) begin
            r_mode      <= n_mode;
            r_val       <= n_val;
            r_stack     <= n_stack;
            r_depth     <= n_depth;
            r_bom       <= n_bom;
            r_u8_rem    <= n_u8_rem;
            r_u8_len    <= n_u8_len;
            r_u8_val    <= n_u8_val;
            r_hex_val   <= n_hex_val;
            r_hex_cnt   <= n_hex_cnt;
            r_lit_idx   <= n_lit_idx;
            r_lit_which <= n_lit_which;
            r_failed    <= n_failed;
        end
    end

    // Output register: loads whenever a byte is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_verdict <= n_out_verdict;
            r_out_level   <= n_depth;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(SD))
        else $error("nesting depth beyond limit");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_failed) |=> (o_verdict == jov_pkg::VERDICT_REJECTED))
        else $error("rejection not held");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_byte) |=> (r_depth == '0 && !r_failed))
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire
